@@ sv/binary_value_scanner_assert.svh @@
// Assertion macros for the checker of the value scanner.
// Depends on nothing; included by the checker module.
`ifndef BINARY_VALUE_SCANNER_ASSERT_SVH
`define BINARY_VALUE_SCANNER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BVS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define BVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ sv/bvs_pkg.sv @@
// Package of the value scanner: types, mode and register codes, character constants and helper functions.
// Depends on nothing.
`default_nettype none
package bvs_pkg;
   localparam int ADDR_BITS = 32;
   localparam int LEN_BITS  = 16;

   localparam logic [3:0] MODE_F64 = 4'd0;
   localparam logic [3:0] MODE_F32 = 4'd1;
   localparam logic [3:0] MODE_I64 = 4'd2;
   localparam logic [3:0] MODE_I32 = 4'd3;
   localparam logic [3:0] MODE_I16 = 4'd4;
   localparam logic [3:0] MODE_S8  = 4'd5;
   localparam logic [3:0] MODE_S16 = 4'd6;
   localparam logic [3:0] MODE_A8  = 4'd7;
   localparam logic [3:0] MODE_A16 = 4'd8;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_LOW  = 2'd1;
   localparam logic [1:0] REG_HIGH = 2'd2;
   localparam logic [1:0] REG_MIN  = 2'd3;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [31:0] match_address;
      logic [15:0] match_length;
      logic [63:0] match_bits;
      logic        is_string;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [63:0] data;
   } csr_type;

   // Total order key for an IEEE double: larger key means larger value.
   function automatic logic [63:0] f64_key(input logic [63:0] x);
      f64_key = x[63] ? ~x : (x | 64'h8000_0000_0000_0000);
   endfunction

   function automatic logic f64_nan(input logic [63:0] x);
      f64_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
   endfunction

   function automatic logic f64_zero(input logic [63:0] x);
      f64_zero = (x[62:0] == 63'd0);
   endfunction

   // a <= b for doubles, false if either is NaN; signed zeros are equal.
   function automatic logic f64_le(input logic [63:0] a, input logic [63:0] b);
      if (f64_nan(a) || f64_nan(b)) f64_le = 1'b0;
      else if (f64_zero(a) && f64_zero(b)) f64_le = 1'b1;
      else f64_le = (f64_key(a) <= f64_key(b));
   endfunction

   function automatic logic [31:0] f32_key(input logic [31:0] x);
      f32_key = x[31] ? ~x : (x | 32'h8000_0000);
   endfunction

   function automatic logic f32_nan(input logic [31:0] x);
      f32_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic f32_le(input logic [31:0] a, input logic [31:0] b);
      if (f32_nan(a) || f32_nan(b)) f32_le = 1'b0;
      else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) f32_le = 1'b1;
      else f32_le = (f32_key(a) <= f32_key(b));
   endfunction

   // Sign-extend the low bytes of a value to 64 bits by width code.
   function automatic logic [63:0] sext_w(input logic [63:0] x, input logic [1:0] w);
      case (w)
         2'd0:    sext_w = {{48{x[15]}}, x[15:0]};
         2'd1:    sext_w = {{32{x[31]}}, x[31:0]};
         default: sext_w = x;
      endcase
   endfunction

   function automatic logic printable(input logic [7:0] b, input logic latin);
      printable = ((b >= 8'h20) && (b <= 8'h7E)) || (latin && (b >= 8'hA0));
   endfunction
endpackage
`default_nettype wire

@@ sv/bvs_stream_if.sv @@
// Valid/ready channel interfaces for the value scanner.
// Depends on bvs_pkg.
`default_nettype none
interface bvs_req_if import bvs_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bvs_rsp_if import bvs_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bvs_csr_if import bvs_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/binary_value_scanner.sv @@
// Byte-stream number and string scanner, top level.
// Depends on bvs_pkg and the channel interfaces in bvs_stream_if.sv.
//
// Usage: bytes of a file enter on req_ (data_byte, file_start); file_start
// marks byte 0 of a new file and clears position and scan state. Each byte
// yields zero or one match on rsp_: start address, length, raw value bits
// and a string flag. The mode and the three 64-bit bounds are written on
// csr_ (index 0 mode, 1 low bound, 2 high bound, 3 minimum magnitude) by
// the user only while the block is idle; the block does not enforce this.
// csr_ready is always high. Latency: a match appears on rsp_ in the cycle
// after its last byte is accepted. Throughput: one byte per cycle while
// rsp_ is not stalled; all decisions for a byte are compares and counter
// updates between the scan state registers and the output register.
// Reset: synchronous, active high; clears configuration, scan state and output valid, mode 0.
// Stall: while rsp_ holds an untaken match, req_ready stays high only if
// the output register is free or is being taken in the same cycle, so no
// match is lost.
`default_nettype none
module binary_value_scanner import bvs_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   bvs_req_if.sink   req,
   bvs_rsp_if.source rsp,
   bvs_csr_if.sink   csr
);
   logic [3:0]  mode_ff;
   logic [63:0] low_ff, high_ff, min_ff;
   logic [63:0] win_ff, win_in;
   logic [3:0]  fill_ff, fill_in;
   logic [ADDR_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [LEN_BITS-1:0]  rlen_ff, rlen_in;
   logic        skip_ff, skip_in, held_ff, held_in;
   logic [7:0]  hbyte_ff, hbyte_in;
   logic        ovalid_ff;
   rsp_type     out_ff, out_in;
   logic        hit;
   logic        accept;

   assign csr.ready = 1'b1;
   assign req.ready = !ovalid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_F64;
         low_ff  <= '0;
         high_ff <= '0;
         min_ff  <= '0;
      end else if (csr.valid) begin
         case (csr.payload.index)
            REG_MODE: mode_ff <= csr.payload.data[3:0];
            REG_LOW:  low_ff  <= csr.payload.data;
            REG_HIGH: high_ff <= csr.payload.data;
            REG_MIN:  min_ff  <= csr.payload.data;
            default:  mode_ff <= mode_ff;
         endcase
      end
   end

   // Per-byte scan logic.
   always_comb begin
      logic [63:0] w0, raw, v, lo, hi, mn, mag, rawf;
      logic [3:0]  f0, wbytes;
      logic [ADDR_BITS-1:0] p0, st, nxt;
      logic [LEN_BITS-1:0]  rl;
      logic        sk, hd, latin, wide, unit_ok, good, term, numhit;
      logic [7:0]  ulo, uhi, hb;
      logic [1:0]  wc;
      logic [31:0] r32;

      win_in = win_ff; fill_in = fill_ff; pos_in = pos_ff; start_in = start_ff;
      rlen_in = rlen_ff; skip_in = skip_ff; held_in = held_ff; hbyte_in = hbyte_ff;
      out_in = out_ff; hit = 1'b0; unit_ok = 1'b0;

      w0 = win_ff; f0 = fill_ff; p0 = pos_ff; st = start_ff; rl = rlen_ff;
      sk = skip_ff; hd = held_ff; hb = hbyte_ff;
      if (req.payload.file_start) begin
         w0 = '0; f0 = '0; p0 = '0; st = '0; rl = '0; sk = 1'b0; hd = 1'b0; hb = '0;
      end
      w0 = {req.payload.data_byte, w0[63:8]};
      if (f0 < 4'd8) f0 = f0 + 4'd1;
      nxt = p0 + 1'b1;

      // Number modes.
      case (mode_ff)
         MODE_F64, MODE_I64: begin wbytes = 4'd8; wc = 2'd2; end
         MODE_F32, MODE_I32: begin wbytes = 4'd4; wc = 2'd1; end
         default:            begin wbytes = 4'd2; wc = 2'd0; end
      endcase
      case (wc)
         2'd0:    raw = {48'd0, w0[63:48]};
         2'd1:    raw = {32'd0, w0[63:32]};
         default: raw = w0;
      endcase
      v  = sext_w(raw, wc);
      lo = sext_w(low_ff, wc);
      hi = sext_w(high_ff, wc);
      mn = sext_w(min_ff, wc);
      mag = v[63] ? (64'd0 - v) : v;
      rawf = {1'b0, raw[62:0]};
      r32 = raw[31:0];
      case (mode_ff)
         MODE_F64: numhit = f64_le(low_ff, raw) && f64_le(raw, high_ff) &&
                            (f64_le(min_ff, rawf) || f64_zero(raw));
         MODE_F32: numhit = f32_le(low_ff[31:0], r32) && f32_le(r32, high_ff[31:0]) &&
                            (f32_le(min_ff[31:0], {1'b0, r32[30:0]}) ||
                             (r32[30:0] == 31'd0));
         default:  numhit = ($signed(lo) <= $signed(v)) && ($signed(v) <= $signed(hi)) &&
                            (mn[63] || (mag >= mn) || (v == 64'd0));
      endcase

      // String modes.
      wide  = (mode_ff == MODE_S16) || (mode_ff == MODE_A16);
      latin = (mode_ff == MODE_S8) || (mode_ff == MODE_S16);
      ulo = wide ? hb : req.payload.data_byte;
      uhi = wide ? req.payload.data_byte : 8'd0;
      good = printable(ulo, latin) && (uhi == 8'd0);
      term = (ulo == CH_NUL) || (ulo == CH_TAB) || (ulo == CH_LF) || (ulo == CH_CR);

      if (mode_ff <= MODE_I16) begin
         if (f0 >= wbytes && numhit) begin
            hit = 1'b1;
            out_in.match_address = p0 - ADDR_BITS'(wbytes - 4'd1);
            out_in.match_length  = 16'(wbytes);
            out_in.match_bits    = raw;
            out_in.is_string     = 1'b0;
         end
      end else if (mode_ff <= MODE_A16) begin
         unit_ok = 1'b1;
         if (wide && !hd) begin
            hd = 1'b1; hb = req.payload.data_byte; unit_ok = 1'b0;
         end else if (wide) begin
            hd = 1'b0;
         end
         if (unit_ok) begin
            if (sk) begin
               if (!good) begin
                  sk = 1'b0; rl = '0;
                  if (wide) begin st = p0; hd = 1'b1; hb = uhi; end
                  else st = nxt;
               end
            end else if (term) begin
               if (64'(rl) >= low_ff) begin
                  hit = 1'b1;
                  out_in.match_address = st;
                  out_in.match_length  = rl;
                  out_in.match_bits    = '0;
                  out_in.is_string     = 1'b1;
                  st = nxt; rl = '0;
               end else begin
                  rl = '0;
                  if (wide) begin st = p0; hd = 1'b1; hb = uhi; end
                  else st = nxt;
               end
            end else if (good && (64'(rl) < high_ff) && (rl != '1)) begin
               rl = rl + 1'b1;
            end else if (good) begin
               sk = 1'b1;
            end else begin
               rl = '0;
               if (wide) begin st = p0; hd = 1'b1; hb = uhi; end
               else st = nxt;
            end
         end
      end

      if (accept) begin
         win_in = w0; fill_in = f0; pos_in = nxt; start_in = st; rlen_in = rl;
         skip_in = sk; held_in = hd; hbyte_in = hb;
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0; fill_ff <= '0; pos_ff <= '0; start_ff <= '0;
         rlen_ff <= '0; skip_ff <= 1'b0; held_ff <= 1'b0; hbyte_ff <= '0;
      end else begin
         win_ff <= win_in; fill_ff <= fill_in; pos_ff <= pos_in; start_ff <= start_in;
         rlen_ff <= rlen_in; skip_ff <= skip_in; held_ff <= held_in; hbyte_ff <= hbyte_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (accept) begin
         ovalid_ff <= hit;
      end else if (rsp.ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) begin
         out_ff <= out_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/bvs_checker.sv @@
// Port-level checker for the value scanner, bound to the top level.
// Depends on bvs_pkg and binary_value_scanner_assert.svh.
`default_nettype none
`include "binary_value_scanner_assert.svh"
module bvs_checker import bvs_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);
   // A stalled match holds.
   `BVS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "match dropped under stall")
   // Input is open whenever the output is free.
   `BVS_ASSERT_IMP(a_ready, clock, reset, !rsp_valid, req_ready, "input blocked while output empty")
   // A match appears only after an accepted item.
   `BVS_ASSERT_NEXT(a_cause, clock, reset, !(req_valid && req_ready) && !(rsp_valid && !rsp_ready), !rsp_valid, "match without an item")
   // Number matches have lengths of 2, 4 or 8 bytes.
   `BVS_ASSERT_IMP(a_len, clock, reset, rsp_valid && !rsp_payload.is_string, rsp_payload.match_length == 16'd2 || rsp_payload.match_length == 16'd4 || rsp_payload.match_length == 16'd8, "bad number length")
endmodule

bind binary_value_scanner bvs_checker u_bvs_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire
